FILE: hdl/kcd_pkg.sv
package kcd_pkg;

   // Default number of keys handled by the block.
   localparam int KEYS_DEFAULT = 2;

   // Field widths.
   localparam int CMD_W   = 2;
   localparam int PINS_W  = 2;
   localparam int INDEX_W = 2;
   localparam int EVENT_W = 3;
   localparam int COUNT_W = 8;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // Register reset values.
   localparam logic [COUNT_W-1:0] SAMPLE_PERIOD_RESET = 8'd20;
   localparam logic [COUNT_W-1:0] LONG_LIMIT_RESET    = 8'd50;
   localparam logic [COUNT_W-1:0] GAP_LIMIT_RESET     = 8'd10;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
   localparam logic [1:0] REG_LONG_LIMIT    = 2'd1;
   localparam logic [1:0] REG_GAP_LIMIT     = 2'd2;

   // Bit positions of the event flags.
   localparam int EV_CLICK  = 0;
   localparam int EV_DOUBLE = 1;
   localparam int EV_LONG   = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_CHECK = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HELD = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0] sample_period;
      logic [COUNT_W-1:0] long_limit;
      logic [COUNT_W-1:0] gap_limit;
   } cfg_type;

   typedef struct packed {
      logic               last_level;
      phase_type          phase;
      logic [COUNT_W-1:0] hold_count;
      logic [EVENT_W-1:0] flags;
   } key_state_type;

endpackage

FILE: hdl/kcd_if.sv
interface kcd_req_if import kcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [PINS_W-1:0]  pin_levels;
   logic [INDEX_W-1:0] key_index;
   logic [EVENT_W-1:0] event_mask;

   modport source (output valid, command, pin_levels, key_index, event_mask, input ready);
   modport sink   (input valid, command, pin_levels, key_index, event_mask, output ready);
endinterface

interface kcd_rsp_if import kcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [EVENT_W-1:0] pending_flags;

   modport source (output valid, hit, pending_flags, input ready);
   modport sink   (input valid, hit, pending_flags, output ready);
endinterface

FILE: hdl/kcd_csr.sv
module kcd_csr import kcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_SAMPLE_PERIOD: cfg_in.sample_period = pwdata[COUNT_W-1:0];
            REG_LONG_LIMIT:    cfg_in.long_limit    = pwdata[COUNT_W-1:0];
            REG_GAP_LIMIT:     cfg_in.gap_limit     = pwdata[COUNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_SAMPLE_PERIOD: prdata = CSR_DW'(cfg_ff.sample_period);
         REG_LONG_LIMIT:    prdata = CSR_DW'(cfg_ff.long_limit);
         REG_GAP_LIMIT:     prdata = CSR_DW'(cfg_ff.gap_limit);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period <= SAMPLE_PERIOD_RESET;
         cfg_ff.long_limit    <= LONG_LIMIT_RESET;
         cfg_ff.gap_limit     <= GAP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/kcd_inc_cmp.sv
module kcd_inc_cmp import kcd_pkg::*; (
   input  logic [COUNT_W-1:0] operand,
   input  logic [COUNT_W-1:0] limit,
   output logic [COUNT_W-1:0] sum,
   output logic               reached
);

   // Wrapping 8-bit increment followed by an unsigned threshold compare.
   assign sum     = operand + COUNT_W'(1);
   assign reached = (sum >= limit);

endmodule

FILE: hdl/kcd_key_step.sv
module kcd_key_step import kcd_pkg::*; (
   input  key_state_type      cur,
   input  logic               level,
   input  logic [COUNT_W-1:0] count_sum,
   input  logic               count_reached,
   output key_state_type      nxt
);

   logic press;
   logic release_edge;

   assign press        = cur.last_level && !level;
   assign release_edge = !cur.last_level && level;

   always_comb begin
      nxt            = cur;
      nxt.last_level = level;
      case (cur.phase)
         PH_HELD: begin
            nxt.hold_count = count_sum;
            if (count_reached) begin
               nxt.phase          = PH_IDLE;
               nxt.flags[EV_LONG] = 1'b1;
            end
            if (release_edge) begin
               nxt.phase      = PH_GAP;
               nxt.hold_count = '0;
            end
         end
         PH_GAP: begin
            nxt.hold_count = count_sum;
            if (count_reached) begin
               nxt.phase           = PH_IDLE;
               nxt.flags[EV_CLICK] = 1'b1;
            end
            if (release_edge) begin
               nxt.phase            = PH_IDLE;
               nxt.flags[EV_DOUBLE] = 1'b1;
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
            if (press) begin
               nxt.phase      = PH_HELD;
               nxt.hold_count = '0;
            end
         end
      endcase
   end

endmodule

FILE: hdl/key_click_double_long_detector.sv
// Channel  | Direction | Handshake      | Payload
// req_ch   | in        | valid / ready  | command, pin_levels, key_index, event_mask
// rsp_ch   | out       | valid / ready  | hit, pending_flags
// APB      | in / out  | psel, penable  | paddr, pwdata, prdata (always ready)
//
// Every accepted transaction returns exactly one response transaction.
// An accepted transaction goes from its command state (tick, check or clear) to the done
// state, which loads it into the response register; an unused command goes straight to
// done. A tick on which the prescaler expires passes the step state first, because the keys
// are then stepped one per cycle through the single shared incrementer and comparator.
// The input is ready again the cycle after the load. Reset is synchronous and
// active high; it restores the register defaults and clears all key state. While a
// response is stalled, the next request transaction is still accepted and worked on;
// only its final load into the response register waits for the output to drain.
module key_click_double_long_detector import kcd_pkg::*; #(
   parameter int KEYS = KEYS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   kcd_req_if.sink           req_ch,
   kcd_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int KW        = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int AW        = (KW > INDEX_W) ? KW : INDEX_W;
   localparam int PINS_USED = (KEYS < PINS_W) ? KEYS : PINS_W;

   // One-hot sequencer states.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_TICK  = 6'b000010,
      ST_STEP  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_CLEAR = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;

   // Latched request payload.
   logic [PINS_W-1:0]  pins_ff, pins_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [EVENT_W-1:0] mask_ff, mask_in;

   // Prescaler and the key sweep counter.
   logic [COUNT_W-1:0] prescale_ff, prescale_in;
   logic [KW-1:0]      key_ff, key_in;

   // Per-key state, one entry per key.
   key_state_type keys_ff [KEYS];
   key_state_type keys_in [KEYS];

   // Result being built, and the response output register.
   logic               res_hit_ff, res_hit_in;
   logic [EVENT_W-1:0] res_pend_ff, res_pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [EVENT_W-1:0] rsp_pend_ff, rsp_pend_in;

   logic               req_fire;
   logic               rsp_free;
   logic [AW-1:0]      idx_ext;
   logic [KW-1:0]      addr;
   logic               idx_valid;
   key_state_type      cur;
   key_state_type      nxt;
   logic [KEYS-1:0]    levels;
   logic [COUNT_W-1:0] unit_operand;
   logic [COUNT_W-1:0] unit_limit;
   logic [COUNT_W-1:0] unit_sum;
   logic               unit_reached;

   kcd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.pending_flags = rsp_pend_ff;

   // A check reads the key named by the request; a tick sweeps the keys in order.
   assign idx_ext   = AW'(idx_ff);
   assign idx_valid = (32'(idx_ff) < KEYS);
   assign addr      = (state_ff == ST_CHECK) ? idx_ext[KW-1:0] : key_ff;
   assign cur       = keys_ff[addr];

   // Keys beyond the pin field read as released.
   always_comb begin
      levels = '1;
      for (int i = 0; i < PINS_USED; i++) begin
         levels[i] = pins_ff[i];
      end
   end

   // The shared incrementer serves the prescaler during a tick and the hold
   // count of the key being stepped during the sweep.
   always_comb begin
      if (state_ff == ST_TICK) begin
         unit_operand = prescale_ff;
         unit_limit   = cfg.sample_period;
      end else begin
         unit_operand = cur.hold_count;
         unit_limit   = (cur.phase == PH_HELD) ? cfg.long_limit : cfg.gap_limit;
      end
   end

   kcd_inc_cmp u_inc_cmp (
      .operand (unit_operand),
      .limit   (unit_limit),
      .sum     (unit_sum),
      .reached (unit_reached)
   );

   kcd_key_step u_key_step (
      .cur           (cur),
      .level         (levels[key_ff]),
      .count_sum     (unit_sum),
      .count_reached (unit_reached),
      .nxt           (nxt)
   );

   always_comb begin
      state_in     = state_ff;
      pins_in      = pins_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      prescale_in  = prescale_ff;
      key_in       = key_ff;
      keys_in      = keys_ff;
      res_hit_in   = res_hit_ff;
      res_pend_in  = res_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_pend_in  = rsp_pend_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pins_in     = req_ch.pin_levels;
               idx_in      = req_ch.key_index;
               mask_in     = req_ch.event_mask;
               res_hit_in  = 1'b0;
               res_pend_in = '0;
               case (cmd_type'(req_ch.command))
                  CMD_TICK:  state_in = ST_TICK;
                  CMD_CHECK: state_in = ST_CHECK;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_TICK: begin
            // The prescaler expires: sample the pins and sweep every key.
            if (unit_reached) begin
               prescale_in = '0;
               key_in      = '0;
               state_in    = ST_STEP;
            end else begin
               prescale_in = unit_sum;
               state_in    = ST_DONE;
            end
         end
         ST_STEP: begin
            keys_in[key_ff] = nxt;
            if (key_ff == KW'(KEYS - 1)) begin
               state_in = ST_DONE;
            end else begin
               key_in = key_ff + KW'(1);
            end
         end
         ST_CHECK: begin
            if (idx_valid) begin
               res_pend_in = cur.flags;
               if ((cur.flags & mask_ff) != '0) begin
                  keys_in[addr].flags = cur.flags & ~mask_ff;
                  res_hit_in          = 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            for (int i = 0; i < KEYS; i++) begin
               keys_in[i].flags = '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait for the response register to be free, then hand the result over.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_pend_in  = res_pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prescale_ff  <= '0;
         key_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEYS; i++) begin
            keys_ff[i] <= '{last_level: 1'b0, phase: PH_IDLE, hold_count: '0, flags: '0};
         end
      end else begin
         state_ff     <= state_in;
         prescale_ff  <= prescale_in;
         key_ff       <= key_in;
         rsp_valid_ff <= rsp_valid_in;
         keys_ff      <= keys_in;
      end
   end

   always_ff @(posedge clock) begin
      pins_ff     <= pins_in;
      idx_ff      <= idx_in;
      mask_ff     <= mask_in;
      res_hit_ff  <= res_hit_in;
      res_pend_ff <= res_pend_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_pend_ff <= rsp_pend_in;
   end

endmodule

FILE: hdl/kcd_checker.sv
module kcd_checker import kcd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [EVENT_W-1:0] rsp_pending_flags
);

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_pending_flags))
      else $error("response changed while stalled");

   // A hit always reports at least one pending flag.
   a_hit_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_pending_flags != '0)
      else $error("hit without pending flags");

   // The block works on one transaction at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind key_click_double_long_detector kcd_checker u_kcd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_hit           (rsp_ch.hit),
   .rsp_pending_flags (rsp_ch.pending_flags)
);

FILE: sim/detector_checker.sv
`timescale 1ns / 100ps

module detector_checker import kcd_pkg::*; #(
   parameter int KEYS = KEYS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   kcd_req_if                req_ch,
   kcd_rsp_if                rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   input  logic [CSR_DW-1:0] prdata,
   input  logic              pready,
   output int                failures,
   output int                outstanding
);

   typedef struct packed {
      logic               hit;
      logic [EVENT_W-1:0] pending_flags;
   } detector_report_t;

   // Shadow copy of the detector: registers, prescaler and per-key machines.
   cfg_type            cfg;
   logic [COUNT_W-1:0] prescale;
   key_state_type      keys [KEYS];

   detector_report_t   expected_reports [$];

   function automatic void advance_key(input int k, input logic level);
      logic prev;
      logic press;
      logic release_edge;
      prev         = keys[k].last_level;
      press        = prev && !level;
      release_edge = !prev && level;
      keys[k].last_level = level;
      case (keys[k].phase)
         PH_HELD: begin
            keys[k].hold_count = keys[k].hold_count + 1'b1;
            if (keys[k].hold_count >= cfg.long_limit) begin
               keys[k].phase           = PH_IDLE;
               keys[k].flags[EV_LONG]  = 1'b1;
            end
            if (release_edge) begin
               keys[k].phase      = PH_GAP;
               keys[k].hold_count = '0;
            end
         end
         PH_GAP: begin
            keys[k].hold_count = keys[k].hold_count + 1'b1;
            if (keys[k].hold_count >= cfg.gap_limit) begin
               keys[k].phase           = PH_IDLE;
               keys[k].flags[EV_CLICK] = 1'b1;
            end
            if (release_edge) begin
               keys[k].phase            = PH_IDLE;
               keys[k].flags[EV_DOUBLE] = 1'b1;
            end
         end
         default: begin
            keys[k].phase = PH_IDLE;
            if (press) begin
               keys[k].phase      = PH_HELD;
               keys[k].hold_count = '0;
            end
         end
      endcase
   endfunction

   function automatic detector_report_t detector_step(input logic [CMD_W-1:0] command,
                                                      input logic [PINS_W-1:0] pins,
                                                      input logic [INDEX_W-1:0] index,
                                                      input logic [EVENT_W-1:0] mask);
      detector_report_t report;
      report = '0;
      case (command)
         CMD_TICK: begin
            prescale = prescale + 1'b1;
            if (prescale >= cfg.sample_period) begin
               prescale = '0;
               // Keys beyond the pin field read as released.
               for (int k = 0; k < KEYS; k++)
                  advance_key(k, (k < PINS_W) ? pins[k] : 1'b1);
            end
         end
         CMD_CHECK: begin
            if (index < KEYS) begin
               report.pending_flags = keys[index].flags;
               if ((keys[index].flags & mask) != '0) begin
                  keys[index].flags = keys[index].flags & ~mask;
                  report.hit        = 1'b1;
               end
            end
         end
         CMD_CLEAR: begin
            for (int k = 0; k < KEYS; k++)
               keys[k].flags = '0;
         end
         default: ;
      endcase
      return report;
   endfunction

   function automatic logic [CSR_DW-1:0] register_value(input logic [CSR_AW-1:0] addr);
      case (addr[CSR_AW-1:2])
         REG_SAMPLE_PERIOD: return CSR_DW'(cfg.sample_period);
         REG_LONG_LIMIT:    return CSR_DW'(cfg.long_limit);
         REG_GAP_LIMIT:     return CSR_DW'(cfg.gap_limit);
         default:           return '0;
      endcase
   endfunction

   always @(posedge clock) begin
      detector_report_t want;
      if (reset) begin
         cfg      = '{SAMPLE_PERIOD_RESET, LONG_LIMIT_RESET, GAP_LIMIT_RESET};
         prescale = '0;
         for (int k = 0; k < KEYS; k++)
            keys[k] = '0;
         expected_reports.delete();
         failures = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
               $error("response transaction with nothing expected: hit %0d, pending_flags %0h",
                      rsp_ch.hit, rsp_ch.pending_flags);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_ch.hit !== want.hit) begin
                  $error("hit mismatch: expected %0d, actual %0d", want.hit, rsp_ch.hit);
                  failures++;
               end
               if (rsp_ch.pending_flags !== want.pending_flags) begin
                  $error("pending_flags mismatch: expected %0h, actual %0h",
                         want.pending_flags, rsp_ch.pending_flags);
                  failures++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_reports.push_back(detector_step(req_ch.command, req_ch.pin_levels,
                                                     req_ch.key_index, req_ch.event_mask));
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[CSR_AW-1:2])
                  REG_SAMPLE_PERIOD: cfg.sample_period = pwdata[COUNT_W-1:0];
                  REG_LONG_LIMIT:    cfg.long_limit    = pwdata[COUNT_W-1:0];
                  REG_GAP_LIMIT:     cfg.gap_limit     = pwdata[COUNT_W-1:0];
                  default: ;
               endcase
            end else if (prdata !== register_value(paddr)) begin
               $error("prdata mismatch at %0h: expected %0h, actual %0h",
                      paddr, register_value(paddr), prdata);
               failures++;
            end
         end
      end
      outstanding = expected_reports.size();
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench import kcd_pkg::*; ();

   localparam int NUM_KEYS    = KEYS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   // Idle margin before the registers change. The block is already idle once
   // the last response has left, since it returns to idle as it loads the
   // response register.
   localparam int SETTLE      = 8;
   localparam int NUM_PHASES  = 12;

   // Command code that the block must ignore.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [EVENT_W-1:0] MASK_CLICK  = EVENT_W'(1 << EV_CLICK);
   localparam logic [EVENT_W-1:0] MASK_DOUBLE = EVENT_W'(1 << EV_DOUBLE);
   localparam logic [EVENT_W-1:0] MASK_LONG   = EVENT_W'(1 << EV_LONG);
   localparam logic [EVENT_W-1:0] MASK_NONE   = '0;
   localparam logic [EVENT_W-1:0] MASK_ALL    = '1;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   int                failures;
   int                outstanding;
   int                cycle_count;

   kcd_req_if req_ch ();
   kcd_rsp_if rsp_ch ();

   key_click_double_long_detector dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   detector_checker #(.KEYS(NUM_KEYS)) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // Register settings of the random phases. The first rows keep the timing
   // short so that keys run through all three phases often; the middle rows
   // hold the extremes of each register, and one row restores the reset values.
   int phase_period [NUM_PHASES] = '{1, 2, 1, 3, 1, 255, 1, 1, 20, 1, 2, 1};
   int phase_long   [NUM_PHASES] = '{3, 6, 1, 2, 8, 255, 255, 2, 50, 5, 1, 4};
   int phase_gap    [NUM_PHASES] = '{4, 3, 1, 5, 2, 255, 1, 255, 10, 6, 8, 3};
   int phase_items  [NUM_PHASES] = '{200, 150, 120, 150, 150, 100, 400, 120, 100, 200,
                                     120, 140};

   // Register values currently programmed; they shape the key press lengths.
   int cur_period;
   int cur_long;
   int cur_gap;

   // Intended level of each key and the ticks left before it toggles.
   logic [PINS_W-1:0] key_levels;
   int                run_left [NUM_KEYS];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offers one request transaction and returns at the falling edge after it
   // was accepted. Valid is left high so that a burst continues without a gap.
   task automatic offer_command(input logic [CMD_W-1:0] command,
                                input logic [PINS_W-1:0] pins,
                                input logic [INDEX_W-1:0] index,
                                input logic [EVENT_W-1:0] mask);
      req_ch.valid      <= 1'b1;
      req_ch.command    <= command;
      req_ch.pin_levels <= pins;
      req_ch.key_index  <= index;
      req_ch.event_mask <= mask;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // One APB transfer: a setup phase, then an access phase that completes
   // when pready is high. The select is left up so that transfers can follow
   // each other; release_bus drops it once the sequence is over.
   task automatic bus_transfer(input logic write, input logic [1:0] reg_index,
                               input logic [COUNT_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= CSR_DW'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
   endtask

   task automatic release_bus();
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Registers may only change while the block is idle, so drain every
   // outstanding response first and let the pipeline settle. Each register is
   // read back after it was written; the checker compares the read data.
   task automatic program_detector(input int period, input int long_lim, input int gap_lim);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      bus_transfer(1'b1, REG_SAMPLE_PERIOD, COUNT_W'(period));
      bus_transfer(1'b1, REG_LONG_LIMIT, COUNT_W'(long_lim));
      bus_transfer(1'b1, REG_GAP_LIMIT, COUNT_W'(gap_lim));
      bus_transfer(1'b0, REG_SAMPLE_PERIOD, '0);
      bus_transfer(1'b0, REG_LONG_LIMIT, '0);
      bus_transfer(1'b0, REG_GAP_LIMIT, '0);
      release_bus();
      cur_period = period;
      cur_long   = long_lim;
      cur_gap    = gap_lim;
   endtask

   // Length of the next press or release, in ticks. The choices aim at the
   // interesting boundaries: short enough for a double click, right around the
   // gap limit for a single click, and right around the long limit.
   function automatic int pick_run_ticks();
      int samples;
      case ($urandom_range(0, 3))
         0:       samples = $urandom_range(1, cur_gap);
         1:       samples = cur_gap + $urandom_range(0, 2);
         2:       samples = ((cur_long > 1) ? cur_long - 1 : 1) + $urandom_range(0, 2);
         default: samples = $urandom_range(1, 3);
      endcase
      return samples * cur_period;
   endfunction

   // Builds one random request transaction. Most are ticks that follow the
   // intended key levels, so that presses, holds and releases form proper
   // sequences; a few ticks carry random levels as noise. Checks mostly ask
   // about existing keys, sometimes about an index beyond the last key.
   task automatic next_random_command(output logic [CMD_W-1:0] command,
                                      output logic [PINS_W-1:0] pins,
                                      output logic [INDEX_W-1:0] index,
                                      output logic [EVENT_W-1:0] mask);
      int pick;
      pick  = $urandom_range(0, 99);
      pins  = PINS_W'($urandom);
      index = INDEX_W'($urandom);
      mask  = EVENT_W'($urandom);
      if (pick < 68) begin
         command = CMD_TICK;
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (run_left[k] == 0) begin
               key_levels[k] = ~key_levels[k];
               run_left[k]   = pick_run_ticks();
            end else begin
               run_left[k]--;
            end
         end
         if ($urandom_range(0, 99) >= 8)
            pins = key_levels;
      end else if (pick < 93) begin
         command = CMD_CHECK;
         if ($urandom_range(0, 9) == 0)
            index = INDEX_W'($urandom_range(NUM_KEYS, (1 << INDEX_W) - 1));
         else
            index = INDEX_W'($urandom_range(0, NUM_KEYS - 1));
      end else if (pick < 97) begin
         command = CMD_CLEAR;
      end else begin
         command = CMD_UNUSED;
      end
   endtask

   // The response side stalls on its own pattern, switching between always
   // ready, random stalls, light stalls and a periodic pattern. Twice it holds
   // off for a long stretch while requests are being offered, so that the
   // block fills up and has to stall its input.
   initial begin : response_stall
      int rx_cycle;
      int mode;
      int hold_left;
      int holds_done;
      rx_cycle     = 0;
      mode         = 0;
      hold_left    = 0;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle % 48 == 0)
            mode = $urandom_range(0, 3);
         if (hold_left == 0 && holds_done < 2 && rx_cycle > 2500 * (holds_done + 1)
             && req_ch.valid) begin
            hold_left = 300;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ((rx_cycle % 8) < 5);
            endcase
         end
      end
   end

   initial begin : stimulus
      int                 burst_left;
      int                 gap;
      logic [CMD_W-1:0]   command;
      logic [PINS_W-1:0]  pins;
      logic [INDEX_W-1:0] index;
      logic [EVENT_W-1:0] mask;

      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_ch.valid      = 1'b0;
      req_ch.command    = CMD_TICK;
      req_ch.pin_levels = '0;
      req_ch.key_index  = '0;
      req_ch.event_mask = '0;
      cycle_count       = 0;
      key_levels        = '0;
      for (int k = 0; k < NUM_KEYS; k++)
         run_left[k] = 0;
      cur_period = SAMPLE_PERIOD_RESET;
      cur_long   = LONG_LIMIT_RESET;
      cur_gap    = GAP_LIMIT_RESET;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the reset register values: the unused command with
      // every field at its maximum, checks on a clean key and on an index
      // beyond the last key, a tick that does not reach a sample, and a clear.
      offer_command(CMD_UNUSED, 2'b11, 2'd3, MASK_ALL);
      offer_command(CMD_CHECK, 2'b00, 2'd0, MASK_ALL);
      offer_command(CMD_CHECK, 2'b11, 2'd3, MASK_ALL);
      offer_command(CMD_TICK, 2'b11, 2'd0, MASK_NONE);
      offer_command(CMD_CLEAR, 2'b00, 2'd0, MASK_NONE);

      // With every tick a sample and a long limit of one, key 0 is pressed and
      // released on consecutive samples, so the long flag and the release edge
      // coincide; it is pressed again in the gap and released just as the gap
      // limit is reached, which sets click and double together. Key 1 is held
      // into a long press and released while idle.
      program_detector(1, 1, 2);
      offer_command(CMD_TICK, 2'b11, 2'd0, MASK_NONE);
      offer_command(CMD_TICK, 2'b10, 2'd0, MASK_NONE);
      offer_command(CMD_TICK, 2'b01, 2'd0, MASK_NONE);
      offer_command(CMD_TICK, 2'b00, 2'd0, MASK_NONE);
      offer_command(CMD_TICK, 2'b11, 2'd0, MASK_NONE);
      offer_command(CMD_CHECK, 2'b00, 2'd0, MASK_CLICK);
      offer_command(CMD_CHECK, 2'b00, 2'd0, MASK_ALL);
      offer_command(CMD_CHECK, 2'b00, 2'd1, MASK_DOUBLE);
      offer_command(CMD_CHECK, 2'b00, 2'd1, MASK_NONE);
      offer_command(CMD_CHECK, 2'b00, 2'd1, MASK_LONG);
      offer_command(CMD_TICK, 2'b00, 2'd0, MASK_NONE);
      offer_command(CMD_CLEAR, 2'b11, 2'd3, MASK_ALL);
      offer_command(CMD_CHECK, 2'b00, 2'd2, MASK_ALL);

      // Random phases. Each starts with a drained block and a new register
      // setting; requests then come in bursts of random length separated by
      // random gaps, a third of the gaps being empty.
      for (int p = 0; p < NUM_PHASES; p++) begin
         program_detector(phase_period[p], phase_long[p], phase_gap[p]);
         burst_left = 0;
         for (int i = 0; i < phase_items[p]; i++) begin
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               if (gap > 0) begin
                  req_ch.valid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            next_random_command(command, pins, index, mask);
            offer_command(command, pins, index, mask);
            burst_left--;
         end
      end

      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
